// ===== design/tcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfd_pkg
// Shared types and constants for the thermal camera frame deframer.
// ----------------------------------------------------------------------------
package tcfd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_JPEG   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Register indexes
  localparam int unsigned REG_MAGIC = 0;

  // Job handed from the front end to the back end: up to two results
  typedef struct packed {
    logic        has_data;
    logic [1:0]  kind;
    logic [15:0] value;
    logic [6:0]  row;
    logic [7:0]  col;
    logic        has_end;
    logic [31:0] seq;
  } job_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [6:0]  row;
    logic [7:0]  col;
    logic [31:0] seq;
    logic        last;
  } res_t;

endpackage

// ===== design/thermal_camera_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// thermal_camera_frame_deframer
// Finds frames in a camera byte stream and emits pixels, JPEG, status bytes
// and end markers.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_     | slave     | tdata[7:0] stream_byte
// out_    | master    | tdata[62:0] value,pixel_row,pixel_col,frame_seq; tuser kind;
//         |           | tlast last_of_run
// cfg_    | APB       | reg 0 magic_word at 0x0
// One byte per cycle enters while the job queue has room; a byte yielding pixel plus
// end marker gives two results, issued in turn through the single result port of the back end.
// Reset clears all control state and the magic word; the input stalls while
// three or more of the four job queue entries are taken, which keeps a slot
// for the job held in the front register.
module thermal_camera_frame_deframer #(
  parameter int IMG_WIDTH      = 160,
  parameter int IMG_HEIGHT     = 120,
  parameter int ROW_WORDS      = 164,
  parameter int HEADER_BYTES   = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // stream_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // value, pixel_row, pixel_col, frame_seq, zero
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] magic_r;
  logic        job_valid, q_room;
  tcfd_pkg::job_t job;
  tcfd_pkg::res_t res;

  // Config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'(tcfd_pkg::REG_MAGIC)) ? magic_r : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) magic_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr == 2'(tcfd_pkg::REG_MAGIC)) magic_r <= cfg_pwdata;
  end

  assign in_tready = q_room;

  tcfd_front #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT),
               .ROW_WORDS(ROW_WORDS), .HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk, .rst_n, .byte_valid(in_tvalid && in_tready), .byte_data(in_tdata),
    .magic(magic_r), .job_valid, .job);

  tcfd_back u_back (
    .clk, .rst_n, .job_valid, .job, .q_room,
    .res_valid(out_tvalid), .res_ready(out_tready), .res);

  assign out_tdata = {1'b0, res.seq, res.col, res.row, res.value};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== design/tcfd_front.sv =====
// ----------------------------------------------------------------------------
// tcfd_front
// Hunts for the magic word, parses the header and classifies body bytes into
// jobs of up to two results.
// ----------------------------------------------------------------------------
module tcfd_front #(
  parameter int IMG_WIDTH      = 160,
  parameter int IMG_HEIGHT     = 120,
  parameter int ROW_WORDS      = 164,
  parameter int HEADER_BYTES   = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          byte_data,
  input  logic [31:0]         magic,
  output logic                job_valid,
  output tcfd_pkg::job_t      job
);

  localparam int HALF = IMG_WIDTH / 2;
  localparam int WCW  = $clog2(ROW_WORDS + 1);
  localparam int RCW  = $clog2(IMG_HEIGHT + 1);

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_BODY} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] win_r, win_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tot_r, tot_nxt, thl_r, thl_nxt, jpl_r, jpl_nxt, stl_r, stl_nxt;
  // precomputed segment ends; a wrapped status end is never reached because
  // the JPEG end then lies beyond every frame position
  logic [32:0] jend_r, jend_nxt, send_r, send_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [RCW-1:0] row_r, row_nxt;
  logic [WCW-1:0] wc_r, wc_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic        jv_nxt;
  tcfd_pkg::job_t job_nxt;

  always_comb begin
    logic [31:0] sh;
    logic [31:0] pt;
    phase_nxt = phase_r; win_nxt = win_r; pos_nxt = pos_r;
    tot_nxt = tot_r; thl_nxt = thl_r; jpl_nxt = jpl_r; stl_nxt = stl_r;
    low_nxt = low_r; row_nxt = row_r; wc_nxt = wc_r; seq_nxt = seq_r;
    jv_nxt = 1'b0;
    job_nxt = '0;
    job_nxt.seq = seq_r;
    sh = {24'd0, byte_data} << {pos_r[1:0], 3'b000};
    pt = pos_r - 32'd4;
    if (byte_valid) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (pos_r >= 32'd8 && pos_r < 32'd24) begin
            unique case (pos_r[3:2])
              2'd2:    tot_nxt = tot_r | sh;
              2'd3:    thl_nxt = thl_r | sh;
              2'd0:    jpl_nxt = jpl_r | sh;
              default: stl_nxt = stl_r | sh;
            endcase
          end
          pos_nxt = pos_r + 32'd1;
          if (pos_nxt >= 32'(HEADER_BYTES)) begin
            if (tot_r == 32'd0 && !(pos_r >= 32'd8 && pos_r < 32'd12)) begin
              job_nxt.has_end = 1'b1; jv_nxt = 1'b1;
            end else if (tot_nxt == 32'd0) begin
              job_nxt.has_end = 1'b1; jv_nxt = 1'b1;
            end
            if (jv_nxt) begin
              seq_nxt = seq_r + 32'd1; phase_nxt = PH_HUNT;
              pos_nxt = '0; win_nxt = '0;
            end else begin
              phase_nxt = PH_BODY; pos_nxt = '0;
              low_nxt = '0; row_nxt = '0; wc_nxt = '0;
            end
          end
        end
        PH_BODY: begin
          if (pos_r < thl_r) begin
            if (pos_r >= 32'd4) begin
              if (!pt[0]) low_nxt = byte_data;
              else begin
                if (32'(row_r) < IMG_HEIGHT) begin
                  job_nxt.kind  = tcfd_pkg::KIND_PIXEL;
                  job_nxt.value = {byte_data, low_r};
                  job_nxt.row   = 7'(row_r);
                  if (32'(wc_r) < HALF) begin
                    job_nxt.has_data = 1'b1; job_nxt.col = 8'(wc_r);
                  end else if (32'(wc_r) >= HALF + 2 && 32'(wc_r) < IMG_WIDTH + 2) begin
                    job_nxt.has_data = 1'b1; job_nxt.col = 8'(wc_r - WCW'(2));
                  end
                end
                if (32'(wc_r) + 1 >= ROW_WORDS) begin
                  wc_nxt = '0;
                  if (32'(row_r) < IMG_HEIGHT) row_nxt = row_r + RCW'(1);
                end else wc_nxt = wc_r + WCW'(1);
              end
            end
          end else if ({1'b0, pos_r} < jend_r) begin
            job_nxt.has_data = 1'b1; job_nxt.kind = tcfd_pkg::KIND_JPEG;
            job_nxt.value = {8'd0, byte_data};
          end else if ({1'b0, pos_r} < send_r) begin
            job_nxt.has_data = 1'b1; job_nxt.kind = tcfd_pkg::KIND_STATUS;
            job_nxt.value = {8'd0, byte_data};
          end
          if (pos_r == tot_r - 32'd1) begin
            job_nxt.has_end = 1'b1;
            seq_nxt = seq_r + 32'd1; phase_nxt = PH_HUNT;
            pos_nxt = '0; win_nxt = '0;
          end else pos_nxt = pos_r + 32'd1;
          jv_nxt = job_nxt.has_data | job_nxt.has_end;
        end
        default: begin
          win_nxt = {byte_data, win_r[31:8]};
          if (pos_r < 32'd4) pos_nxt = pos_r + 32'd1;
          if (pos_nxt >= 32'd4 && win_nxt == magic) begin
            phase_nxt = PH_HEAD; pos_nxt = 32'd4;
            tot_nxt = '0; thl_nxt = '0; jpl_nxt = '0; stl_nxt = '0;
          end
        end
      endcase
    end
    // segment ends follow the lengths as they will be after this edge
    jend_nxt = {1'b0, thl_nxt} + {1'b0, jpl_nxt};
    send_nxt = jend_nxt + {1'b0, stl_nxt};
  end

  // State and job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT; win_r <= '0; pos_r <= '0;
      tot_r <= '0; thl_r <= '0; jpl_r <= '0; stl_r <= '0;
      jend_r <= '0; send_r <= '0;
      low_r <= '0; row_r <= '0; wc_r <= '0; seq_r <= '0;
      job_valid <= 1'b0;
    end else begin
      phase_r <= phase_nxt; win_r <= win_nxt; pos_r <= pos_nxt;
      tot_r <= tot_nxt; thl_r <= thl_nxt; jpl_r <= jpl_nxt; stl_r <= stl_nxt;
      jend_r <= jend_nxt; send_r <= send_nxt;
      low_r <= low_nxt; row_r <= row_nxt; wc_r <= wc_nxt; seq_r <= seq_nxt;
      job_valid <= jv_nxt;
    end
  end

  always_ff @(posedge clk) job <= job_nxt;

  // A job always carries at least one result
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (job.has_data || job.has_end)) else $error("empty job");
  // Frame count moves only with an end marker
  a_seq_end: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != $past(seq_r)) |-> (job_valid && job.has_end)) else $error("seq");
  // Row counter saturates at the image height
  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) <= IMG_HEIGHT) else $error("row overflow");

endmodule

// ===== design/tcfd_back.sv =====
// ----------------------------------------------------------------------------
// tcfd_back
// Job queue plus expander that issues the one or two results of each job.
// ----------------------------------------------------------------------------
module tcfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  tcfd_pkg::job_t      job,
  output logic                q_room,
  output logic                res_valid,
  input  logic                res_ready,
  output tcfd_pkg::res_t      res
);

  localparam int DEPTH = 4;

  tcfd_pkg::job_t mem [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       half_r; // data part of head job already sent
  logic       pop;
  tcfd_pkg::job_t head;

  assign head = mem[rp_r];
  // room for the job in flight in the front register plus one new
  assign q_room = (cnt_r <= 3'(DEPTH - 2));
  assign res_valid = (cnt_r != 3'd0);

  // Current result from head job
  always_comb begin
    res = '0;
    res.seq = head.seq;
    if (head.has_data && !half_r) begin
      res.kind = head.kind; res.value = head.value;
      res.row = head.row; res.col = head.col;
      res.last = !head.has_end;
    end else begin
      res.kind = tcfd_pkg::KIND_END; res.last = 1'b1;
    end
  end
  assign pop = res_valid && res_ready && res.last;

  always_ff @(posedge clk) begin
    if (job_valid) mem[wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; half_r <= 1'b0;
    end else begin
      if (job_valid) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(job_valid) - 3'(pop);
      if (res_valid && res_ready) half_r <= !res.last;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_valid && !pop && cnt_r == 3'(DEPTH))) else $error("queue overflow");
  a_half_dual: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (res_valid && head.has_end)) else $error("half state");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH)) else $error("count");

endmodule

// ===== tb/sv/thermal_camera_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_camera_frame_deframer_tb
// Drives framed camera byte streams (plus line noise and broken sync words)
// into the deframer, predicts every pixel, JPEG, status and end-marker item
// with a local model of the frame parser, and checks the output stream item
// by item under random source and sink stalls.
// ----------------------------------------------------------------------------
module thermal_camera_frame_deframer_tb;

  localparam int IMG_W     = 160;
  localparam int IMG_H     = 120;
  localparam int ROW_WORDS = 164;
  localparam int HDR_BYTES = 28;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [1:0] ADDR_MAGIC = 2'(tcfd_pkg::REG_MAGIC * 4);

  typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_BODY} parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;     // stream_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;           // value, pixel_row, pixel_col, frame_seq, zero
  logic [1:0]  out_tuser;           // kind
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = 2'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  thermal_camera_frame_deframer i_dut (.*);

  always #5 clk = ~clk;

  // Parser shadow state
  logic [31:0]  magic_reg;
  logic [31:0]  sync_win;
  parse_phase_t phase;
  logic [31:0]  pos, frame_len, therm_len, jpeg_len, stat_len, seq_num;
  logic [7:0]   low_hold;
  logic [6:0]   row_idx;
  logic [7:0]   word_idx;

  tcfd_pkg::res_t  expected_items[$];
  tcfd_pkg::res_t  byte_items[2];
  int    byte_item_cnt;
  int    mismatches = 0;
  int    bytes_sent = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    quiet_cycles = 0;

  // ---------------------------------------------------------------- predictor
  task automatic add_item(logic [1:0] kind, logic [15:0] value, logic [6:0] row,
                          logic [7:0] col);
    byte_items[byte_item_cnt] = '{kind: kind, value: value, row: row, col: col,
                                  seq: seq_num, last: 1'b0};
    byte_item_cnt++;
  endtask

  task automatic close_frame();
    add_item(tcfd_pkg::KIND_END, 16'd0, 7'd0, 8'd0);
    seq_num  = seq_num + 1;
    phase    = HUNTING;
    pos      = 0;
    sync_win = 0;
  endtask

  task automatic thermal_word_byte(logic [7:0] b, logic [31:0] o);
    logic [15:0] pix;
    if (o < 4) return;
    if (((o - 4) & 1) == 0) begin
      low_hold = b;
      return;
    end
    pix = {b, low_hold};
    if (row_idx < IMG_H) begin
      if (word_idx < IMG_W / 2)
        add_item(tcfd_pkg::KIND_PIXEL, pix, row_idx, word_idx);
      else if (word_idx >= IMG_W / 2 + 2 && word_idx < IMG_W + 2)
        add_item(tcfd_pkg::KIND_PIXEL, pix, row_idx, word_idx - 8'd2);
    end
    word_idx++;
    if (word_idx >= ROW_WORDS) begin
      word_idx = 0;
      if (row_idx < IMG_H) row_idx++;
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    logic [31:0] sh_byte;
    logic [33:0] t_end, j_end, s_end;
    byte_item_cnt = 0;
    case (phase)
      IN_HEADER: begin
        if (pos >= 8 && pos < 24) begin
          sh_byte = 32'(b) << (8 * pos[1:0]);
          case ((pos - 8) >> 2)
            0: frame_len |= sh_byte;
            1: therm_len |= sh_byte;
            2: jpeg_len  |= sh_byte;
            default: stat_len |= sh_byte;
          endcase
        end
        pos++;
        if (pos >= HDR_BYTES) begin
          if (frame_len == 0) close_frame();
          else begin
            phase = IN_BODY;
            pos = 0;
            low_hold = 0;
            row_idx = 0;
            word_idx = 0;
          end
        end
      end
      IN_BODY: begin
        t_end = 34'(therm_len);
        j_end = t_end + 34'(jpeg_len);
        s_end = j_end + 34'(stat_len);
        if (34'(pos) < t_end) thermal_word_byte(b, pos);
        else if (34'(pos) < j_end) add_item(tcfd_pkg::KIND_JPEG, 16'(b), 7'd0, 8'd0);
        else if (34'(pos) < s_end) add_item(tcfd_pkg::KIND_STATUS, 16'(b), 7'd0, 8'd0);
        if (pos == frame_len - 1) close_frame();
        else pos++;
      end
      default: begin
        phase = HUNTING;
        sync_win = {b, sync_win[31:8]};
        if (pos < 4) pos++;
        if (pos >= 4 && sync_win == magic_reg) begin
          phase = IN_HEADER;
          pos = 4;
          frame_len = 0;
          therm_len = 0;
          jpeg_len = 0;
          stat_len = 0;
        end
      end
    endcase
    if (byte_item_cnt > 0) byte_items[byte_item_cnt-1].last = 1'b1;
    for (int i = 0; i < byte_item_cnt; i++) expected_items.push_back(byte_items[i]);
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Stop the source, wait for every predicted item, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer, after which the bus returns to idle
  task automatic reg_access(logic [1:0] addr, logic wr, logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr && addr == ADDR_MAGIC) magic_reg = wdata;
    if (!wr && cfg_prdata !== magic_reg) begin
      mismatches++;
      if (mismatches <= 10)
        $display("magic readback: expected %h got %h", magic_reg, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_magic(logic [31:0] m);
    drain();
    reg_access(ADDR_MAGIC, 1'b1, m);
    reg_access(ADDR_MAGIC, 1'b0, 32'd0);
  endtask

  // Magic, filler, four little-endian sizes, filler, then the body bytes
  task automatic send_frame(logic [31:0] m, logic [31:0] total, logic [31:0] therm,
                            logic [31:0] jpg, logic [31:0] stat);
    logic [31:0] word;
    for (int i = 0; i < HDR_BYTES; i++) begin
      case (i / 4)
        0: word = m;
        2: word = total;
        3: word = therm;
        4: word = jpg;
        5: word = stat;
        default: word = $urandom;
      endcase
      send_byte(word[8*(i%4) +: 8]);
    end
    for (logic [31:0] k = 0; k < total; k++) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_zero_magic_after_reset();
    // reset window is zero but needs four fresh bytes before it can match
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_frame(32'h0, 32'd0, 32'd5, 32'd5, 32'd5);
    drain();
  endtask

  task automatic test_segments();
    set_magic(32'hFFFF_FFFF);
    // odd thermal size, JPEG, status and unused tail bytes
    send_frame(32'hFFFF_FFFF, 32'd22, 32'd11, 32'd3, 32'd2);
    // thermal segment runs past the frame end
    send_frame(32'hFFFF_FFFF, 32'd10, 32'd30, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // no thermal, maximal JPEG cut at the frame end
    send_frame(32'hFFFF_FFFF, 32'd6, 32'd0, 32'hFFFF_FFFF, 32'd0);
    // status only, then single-byte frame
    send_frame(32'hFFFF_FFFF, 32'd5, 32'd0, 32'd0, 32'd3);
    send_frame(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_broken_sync_and_registers();
    logic [31:0] m;
    m = 32'h5AA5_C33C;
    set_magic(m);
    // writes outside the register map leave the magic word alone
    for (int a = 1; a < 4; a++) reg_access(2'(a), 1'b1, $urandom);
    reg_access(ADDR_MAGIC, 1'b0, 32'd0);
    send_byte(m[7:0]);
    send_byte(m[15:8]);
    send_byte(8'h00);
    send_byte(m[7:0]);
    send_byte(m[15:8]);
    send_byte(m[23:16]);
    send_frame(m, 32'd4, 32'd4, 32'd0, 32'd0);
    // magic rewritten while the parser sits in a header
    send_byte(m[7:0]); send_byte(m[15:8]); send_byte(m[23:16]); send_byte(m[31:24]);
    set_magic(32'h0102_0304);
    for (int i = 4; i < HDR_BYTES; i++) send_byte(i == 8 ? 8'd2 : 8'h00);
    send_byte(8'h11); send_byte(8'h22);
    send_frame(32'h0102_0304, 32'd3, 32'd0, 32'd1, 32'd1);
    drain();
  endtask

  task automatic test_thermal_row();
    logic [31:0] th;
    // crosses the skipped middle words; odd length leaves a dangling low byte
    th = 4 + 2 * (IMG_W / 2 + 3) + 1;
    send_frame(32'h0102_0304, th + 2, th, 32'd1, 32'd1);
    drain();
  endtask

  task automatic test_random_stream(int s_pct, int r_pct, int n_bytes);
    logic [31:0] m, total, th, jp, st;
    int start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    m = $urandom;
    set_magic(m);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      if ($urandom_range(5) == 0) begin
        // broken sync: a prefix of the magic word then junk
        for (int i = 0; i < $urandom_range(1, 3); i++) send_byte(m[8*i +: 8]);
        send_byte(8'($urandom));
      end
      total = $urandom_range(0, 48);
      th = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, total + 6);
      if ($urandom_range(14) == 0) begin
        th = $urandom_range(170, 400);
        total = th + $urandom_range(0, 8);
      end
      jp = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 12);
      st = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 12);
      send_frame(m, total, th, jp, st);
    end
    drain();
  endtask

  // ---------------------------------------------------------------- sink
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Compare each output item against the oldest prediction
  always @(posedge clk) begin
    tcfd_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, value: out_tdata[15:0], row: out_tdata[22:16],
              col: out_tdata[30:23], seq: out_tdata[62:31], last: out_tlast};
      if (expected_items.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = expected_items.pop_front();
        if (got !== want || out_tdata[63] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10) $display("item mismatch: expected %p got %p", want, got);
        end
      end
    end
    // watchdog on cycles with no handshake on either stream
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    magic_reg = 0; sync_win = 0; phase = HUNTING; pos = 0; frame_len = 0;
    therm_len = 0; jpeg_len = 0; stat_len = 0; low_hold = 0; row_idx = 0;
    word_idx = 0; seq_num = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 80;
    test_zero_magic_after_reset();
    test_segments();
    test_broken_sync_and_registers();
    test_thermal_row();
    test_random_stream(14, 80, 30);
    test_random_stream(80, 14, 30);
    test_random_stream(0, 0, 30);
    drain();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
